>>> rtl/cpgi_pkg.sv
// cpgi_pkg: types, constants and helper functions for the circular pattern
// gain interpolator; no dependencies, compiled first
package cpgi_pkg;

  // angle and gain ranges
  localparam logic [15:0] FULL_TURN = 16'd23040;
  localparam int GAIN_MIN = -16384;
  localparam int GAIN_MAX = 12288;

  // dB to linear conversion constants
  localparam logic [31:0] LN10_Q30  = 32'd2472381918;
  localparam logic [33:0] ONE_Q30   = 34'd1073741824;
  localparam logic [15:0] DB_STEP   = 16'd2560;
  localparam logic [15:0] DB_OFFSET = 16'd17920;
  localparam logic [4:0]  TERMS     = 5'd24;

  // reciprocal of five, 2^34 / 5 rounded up, exact for dividends below 2^34
  localparam logic [31:0] RECIP5    = 32'd3435973837;

  // shared divider widths
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 40;

  // item opcodes and result status codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_RD_LO, S_RD_HI, S_RD_WAIT, S_SPAN, S_IMUL, S_IDIV, S_IWAIT,
    S_CONV, S_DB, S_XMUL, S_XDIV, S_XWAIT, S_TMUL, S_TDIV, S_TWAIT,
    S_FIN, S_FMUL, S_FRND, S_FDIV, S_FWAIT, S_OUT
  } cpgi_state_t;

  // divider request and response
  typedef struct packed {
    logic       start;
    logic [5:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  // powers of ten up to ten million
  function automatic logic [23:0] pow10(input logic [2:0] e);
    logic [23:0] p;
    case (e)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

  // saturate a gain to the output range
  function automatic logic signed [14:0] clamp_db(input logic signed [33:0] v);
    logic signed [14:0] r;
    if (v < 34'(GAIN_MIN)) begin
      r = 15'(GAIN_MIN);
    end else if (v > 34'(GAIN_MAX)) begin
      r = 15'(GAIN_MAX);
    end else begin
      r = v[14:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/cpgi_in_if.sv
// cpgi_in_if: input channel of the gain interpolator, valid/ready plus item
// fields; no dependencies
interface cpgi_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [8:0]         entry_index;
  logic [14:0]        angle;
  logic signed [14:0] entry_gain;

  modport source(output valid, opcode, entry_index, angle, entry_gain, input ready);
  modport sink(input valid, opcode, entry_index, angle, entry_gain, output ready);
endinterface

>>> rtl/cpgi_out_if.sv
// cpgi_out_if: result channel of the gain interpolator, valid/ready plus
// result fields; no dependencies
interface cpgi_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               exact_hit;
  logic signed [14:0] gain_db;
  logic [31:0]        gain_linear;

  modport source(output valid, status, exact_hit, gain_db, gain_linear, input ready);
  modport sink(input valid, status, exact_hit, gain_db, gain_linear, output ready);
endinterface

>>> rtl/cpgi_div.sv
// cpgi_div: shared restoring divider, one quotient bit per cycle
// depends on cpgi_pkg
module cpgi_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cpgi_pkg::div_req_t            req,
  input  logic [cpgi_pkg::DIV_NW-1:0]   dividend,
  input  logic [cpgi_pkg::DIV_DW-1:0]   divisor,
  output cpgi_pkg::div_rsp_t            rsp,
  output logic [cpgi_pkg::DIV_NW-1:0]   quotient
);
  logic [cpgi_pkg::DIV_NW-1:0] q_r;
  logic [cpgi_pkg::DIV_DW-1:0] rem_r;
  logic [cpgi_pkg::DIV_DW-1:0] den_r;
  logic [5:0]                  cnt_r;
  logic                        done_r;
  logic [cpgi_pkg::DIV_DW:0]   trial;
  logic [cpgi_pkg::DIV_DW:0]   diff;
  logic [5:0]                  shamt;

  // one restoring step
  assign trial = {rem_r, q_r[cpgi_pkg::DIV_NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign shamt = 6'(cpgi_pkg::DIV_NW) - req.nbits;

  // step counter and completion flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.nbits;
      end else if (cnt_r != 6'd0) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient and partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= dividend << shamt;
      rem_r <= '0;
      den_r <= divisor;
    end else if (cnt_r != 6'd0) begin
      if (!diff[cpgi_pkg::DIV_DW]) begin
        rem_r <= diff[cpgi_pkg::DIV_DW-1:0];
        q_r   <= {q_r[cpgi_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem_r <= trial[cpgi_pkg::DIV_DW-1:0];
        q_r   <= {q_r[cpgi_pkg::DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = (cnt_r != 6'd0);
  assign rsp.done = done_r;
  assign quotient = q_r;
endmodule

>>> rtl/circular_pattern_gain_interpolator.sv
// circular_pattern_gain_interpolator: pattern table, search, interpolation and
// dB to linear conversion; depends on cpgi_pkg, cpgi_in_if, cpgi_out_if, cpgi_div
//
//  channel   direction  handshake     carries
//  in_chan   in         valid/ready   opcode, entry_index, angle, entry_gain
//  out_chan  out        valid/ready   status, exact_hit, gain_db, gain_linear
//  cfg       in         cfg_we        cfg_data (entry_count)
//
// a write item goes from the idle state straight to the result state; a query
// runs a scan reading one table entry a cycle, then 24 series terms, each
// one pass of the shared multiplier and the bit-serial divider (34 steps)
// in_chan.ready is high only in the idle state; the result register lets the
// next item in while a result waits for out_chan.ready
// reset is synchronous, active low; the table content is undefined until written
module circular_pattern_gain_interpolator #(
  parameter int MAX_ENTRIES = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  cpgi_in_if.sink    in_chan,
  cpgi_out_if.source out_chan,
  input  logic       cfg_we,
  input  logic [9:0] cfg_data
);
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int NW = $clog2(MAX_ENTRIES + 1);

  cpgi_pkg::cpgi_state_t state_r, state_nxt;

  logic [9:0]  cfg_count_r;
  logic [NW-1:0] n_cur;
  logic [NW-1:0] n_r;

  // table memory: angle over gain
  logic [30:0] mem [MAX_ENTRIES];
  logic [30:0] rd_data_r;
  logic [IW-1:0] rd_addr;

  // scan pipeline
  logic [NW-1:0] addr_r;
  logic          chk_vld_r;
  logic [IW-1:0] chk_idx_r;
  logic          fa_found_r;
  logic [IW-1:0] fa_r;
  logic [IW-1:0] lo_r;
  logic [IW-1:0] hi;

  // interpolation operands
  logic [14:0]        q_r;
  logic [14:0]        x1_r, x2_r;
  logic signed [15:0] y1_r, y2_r;
  logic [14:0]        span_r, off_r;
  logic               neg_r;

  // conversion state
  logic [14:0] shf_r;
  logic [3:0]  a_r;
  logic [31:0] x_r;
  logic [31:0] term_r;
  logic [33:0] sum_r;
  logic [4:0]  k_r;

  // work results and output register
  logic [1:0]         st_r;
  logic               hit_r;
  logic signed [14:0] g_r;
  logic [31:0]        lin_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic               out_hit_r;
  logic signed [14:0] out_gdb_r;
  logic [31:0]        out_glin_r;

  // shared multiplier
  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] prod_r;

  // shared divider
  cpgi_pkg::div_req_t          div_req;
  cpgi_pkg::div_rsp_t          div_rsp;
  logic [cpgi_pkg::DIV_NW-1:0] div_dend;
  logic [cpgi_pkg::DIV_DW-1:0] div_dsor;
  logic [cpgi_pkg::DIV_NW-1:0] div_quo;

  // combinational helpers
  logic          in_acc;
  logic          out_load;
  logic [14:0]   in_ang;
  logic          idx_ok;
  logic [14:0]   ck_ang;
  logic signed [15:0] ck_gain;
  logic          ck_hit;
  logic          ck_above;
  logic          ck_last;
  logic          fa_now_found;
  logic [IW-1:0] fa_now;
  logic [IW-1:0] lo_now;
  logic [15:0]   span_w, off_w;
  logic signed [16:0] ydiff;
  logic [16:0]   ymag;
  logic signed [33:0] interp;
  logic [65:0]   prod_rnd_t;
  logic [65:0]   prod_rnd_f;
  logic [51:0]   fin_mul;
  logic [3:0]    a_hi;
  logic [2:0]    e_up;
  logic [2:0]    e_dn;
  logic [37:0]   den_f;
  logic [15:0]   shf_w;
  logic [44:0]   xn_w;

  cpgi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dend),
    .divisor  (div_dsor),
    .rsp      (div_rsp),
    .quotient (div_quo)
  );

  // handshakes
  assign in_chan.ready = (state_r == cpgi_pkg::S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == cpgi_pkg::S_OUT) && (!out_valid_r || out_chan.ready);

  // effective entry count and input angle reduction
  assign n_cur  = (11'(cfg_count_r) > 11'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(cfg_count_r);
  assign in_ang = (16'(in_chan.angle) >= cpgi_pkg::FULL_TURN) ?
                  15'(16'(in_chan.angle) - cpgi_pkg::FULL_TURN) : in_chan.angle;
  assign idx_ok = 11'(in_chan.entry_index) < 11'(n_cur);

  // scan compare stage
  assign ck_ang       = rd_data_r[30:16];
  assign ck_gain      = rd_data_r[15:0];
  assign ck_hit       = chk_vld_r && (ck_ang == q_r);
  assign ck_above     = chk_vld_r && (ck_ang > q_r) && !fa_found_r;
  assign ck_last      = chk_vld_r && (NW'(chk_idx_r) == n_r - NW'(1));
  assign fa_now_found = fa_found_r || ck_above;
  assign fa_now       = fa_found_r ? fa_r : chk_idx_r;
  assign lo_now       = (!fa_now_found || fa_now == '0) ? IW'(n_r - NW'(1)) : fa_now - IW'(1);
  assign hi           = (NW'(lo_r) == n_r - NW'(1)) ? '0 : lo_r + IW'(1);

  // circular distances
  assign span_w = (x2_r >= x1_r) ? 16'(x2_r) - 16'(x1_r)
                                 : 16'(x2_r) + cpgi_pkg::FULL_TURN - 16'(x1_r);
  assign off_w  = (q_r >= x1_r) ? 16'(q_r) - 16'(x1_r)
                                : 16'(q_r) + cpgi_pkg::FULL_TURN - 16'(x1_r);
  assign ydiff  = 17'(y2_r) - 17'(y1_r);
  assign ymag   = ydiff[16] ? 17'(-ydiff) : 17'(ydiff);
  assign interp = neg_r ? 34'(y1_r) - $signed({1'b0, div_quo[32:0]})
                        : 34'(y1_r) + $signed({1'b0, div_quo[32:0]});

  // conversion helpers
  assign shf_w      = 16'(g_r) + cpgi_pkg::DB_OFFSET;
  assign xn_w       = 45'(prod_r[43:0]) + 45'(cpgi_pkg::DB_STEP >> 1);
  assign prod_rnd_t = prod_r + 66'd536870912;
  assign prod_rnd_f = prod_r + 66'd8192;
  assign fin_mul    = prod_rnd_f[65:14];
  assign a_hi       = a_r - 4'd7;
  assign e_up       = (a_hi > 4'd7) ? 3'd7 : a_hi[2:0];
  assign e_dn       = 3'(4'd7 - a_r);
  assign den_f      = {cpgi_pkg::pow10(e_dn), 14'd0};

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpgi_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and shared unit control
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    rd_addr   = addr_r[IW-1:0];
    div_req   = '0;
    div_dend  = '0;
    div_dsor  = '0;
    case (state_r)
      cpgi_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_chan.opcode == cpgi_pkg::OP_WRITE || n_cur == '0) begin
            state_nxt = cpgi_pkg::S_OUT;
          end else begin
            state_nxt = cpgi_pkg::S_SCAN;
          end
        end
      end
      cpgi_pkg::S_SCAN: begin
        if (ck_hit) begin
          state_nxt = cpgi_pkg::S_CONV;
        end else if (ck_last) begin
          state_nxt = cpgi_pkg::S_RD_LO;
        end
      end
      cpgi_pkg::S_RD_LO: begin
        rd_addr   = lo_r;
        state_nxt = cpgi_pkg::S_RD_HI;
      end
      cpgi_pkg::S_RD_HI: begin
        rd_addr   = hi;
        state_nxt = cpgi_pkg::S_RD_WAIT;
      end
      cpgi_pkg::S_RD_WAIT: begin
        state_nxt = cpgi_pkg::S_SPAN;
      end
      cpgi_pkg::S_SPAN: begin
        state_nxt = (span_w == 16'd0) ? cpgi_pkg::S_CONV : cpgi_pkg::S_IMUL;
      end
      cpgi_pkg::S_IMUL: begin
        mul_a     = 34'(ymag);
        mul_b     = 32'(off_r);
        state_nxt = cpgi_pkg::S_IDIV;
      end
      cpgi_pkg::S_IDIV: begin
        div_req.start = 1'b1;
        div_req.nbits = 6'd33;
        div_dend      = 48'(prod_r[31:0]) + 48'(span_r >> 1);
        div_dsor      = 40'(span_r);
        state_nxt     = cpgi_pkg::S_IWAIT;
      end
      cpgi_pkg::S_IWAIT: begin
        if (div_rsp.done) begin
          state_nxt = cpgi_pkg::S_CONV;
        end
      end
      cpgi_pkg::S_CONV: begin
        state_nxt = cpgi_pkg::S_DB;
      end
      cpgi_pkg::S_DB: begin
        if (16'(shf_r) < cpgi_pkg::DB_STEP) begin
          state_nxt = cpgi_pkg::S_XMUL;
        end
      end
      cpgi_pkg::S_XMUL: begin
        mul_a     = 34'(shf_r);
        mul_b     = cpgi_pkg::LN10_Q30;
        state_nxt = cpgi_pkg::S_XDIV;
      end
      cpgi_pkg::S_XDIV: begin
        // divide by 2560: shift out 2^9, then multiply by the reciprocal of five
        mul_a     = xn_w[42:9];
        mul_b     = cpgi_pkg::RECIP5;
        state_nxt = cpgi_pkg::S_XWAIT;
      end
      cpgi_pkg::S_XWAIT: begin
        state_nxt = cpgi_pkg::S_TMUL;
      end
      cpgi_pkg::S_TMUL: begin
        mul_a     = 34'(term_r);
        mul_b     = x_r;
        state_nxt = cpgi_pkg::S_TDIV;
      end
      cpgi_pkg::S_TDIV: begin
        div_req.start = 1'b1;
        div_req.nbits = 6'd34;
        div_dend      = 48'(prod_rnd_t[63:30]) + 48'(k_r >> 1);
        div_dsor      = 40'(k_r);
        state_nxt     = cpgi_pkg::S_TWAIT;
      end
      cpgi_pkg::S_TWAIT: begin
        if (div_rsp.done) begin
          state_nxt = (k_r == cpgi_pkg::TERMS) ? cpgi_pkg::S_FIN : cpgi_pkg::S_TMUL;
        end
      end
      cpgi_pkg::S_FIN: begin
        state_nxt = (a_r >= 4'd7) ? cpgi_pkg::S_FMUL : cpgi_pkg::S_FDIV;
      end
      cpgi_pkg::S_FMUL: begin
        mul_a     = sum_r;
        mul_b     = 32'(cpgi_pkg::pow10(e_up));
        state_nxt = cpgi_pkg::S_FRND;
      end
      cpgi_pkg::S_FRND: begin
        state_nxt = cpgi_pkg::S_OUT;
      end
      cpgi_pkg::S_FDIV: begin
        div_req.start = 1'b1;
        div_req.nbits = 6'd38;
        div_dend      = 48'(sum_r) + 48'(den_f >> 1);
        div_dsor      = 40'(den_f);
        state_nxt     = cpgi_pkg::S_FWAIT;
      end
      cpgi_pkg::S_FWAIT: begin
        if (div_rsp.done) begin
          state_nxt = cpgi_pkg::S_OUT;
        end
      end
      cpgi_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = cpgi_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cpgi_pkg::S_IDLE;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
    end else if (cfg_we) begin
      cfg_count_r <= cfg_data;
    end
  end

  // table memory: write on an accepted write item with an index in range, registered read
  always_ff @(posedge clk) begin
    if (in_acc && in_chan.opcode == cpgi_pkg::OP_WRITE && idx_ok) begin
      mem[IW'(in_chan.entry_index)] <= {in_ang, 16'(in_chan.entry_gain)};
    end
    rd_data_r <= mem[rd_addr];
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod_r <= 66'(mul_a) * 66'(mul_b);
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r  <= 1'b0;
      fa_found_r <= 1'b0;
      addr_r     <= '0;
    end else if (in_acc) begin
      chk_vld_r  <= 1'b0;
      fa_found_r <= 1'b0;
      addr_r     <= '0;
    end else if (state_r == cpgi_pkg::S_SCAN) begin
      chk_vld_r <= (addr_r < n_r);
      if (addr_r < n_r) begin
        addr_r <= addr_r + NW'(1);
      end
      if (ck_above) begin
        fa_found_r <= 1'b1;
      end
    end else begin
      chk_vld_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      cpgi_pkg::S_IDLE: begin
        if (in_acc) begin
          q_r   <= in_ang;
          n_r   <= n_cur;
          hit_r <= 1'b0;
          g_r   <= '0;
          lin_r <= '0;
          if (in_chan.opcode == cpgi_pkg::OP_WRITE) begin
            st_r <= idx_ok ? cpgi_pkg::ST_OK : cpgi_pkg::ST_BAD_INDEX;
          end else begin
            st_r <= (n_cur == '0) ? cpgi_pkg::ST_EMPTY : cpgi_pkg::ST_OK;
          end
        end
      end
      cpgi_pkg::S_SCAN: begin
        chk_idx_r <= addr_r[IW-1:0];
        if (ck_above) begin
          fa_r <= chk_idx_r;
        end
        if (ck_hit) begin
          hit_r <= 1'b1;
          g_r   <= cpgi_pkg::clamp_db(34'(ck_gain));
        end else if (ck_last) begin
          lo_r <= lo_now;
        end
      end
      cpgi_pkg::S_RD_HI: begin
        x1_r <= ck_ang;
        y1_r <= ck_gain;
      end
      cpgi_pkg::S_RD_WAIT: begin
        x2_r <= ck_ang;
        y2_r <= ck_gain;
      end
      cpgi_pkg::S_SPAN: begin
        span_r <= span_w[14:0];
        off_r  <= (off_w > span_w) ? span_w[14:0] : off_w[14:0];
        neg_r  <= ydiff[16];
        if (span_w == 16'd0) begin
          g_r <= cpgi_pkg::clamp_db(34'(y1_r));
        end
      end
      cpgi_pkg::S_IWAIT: begin
        if (div_rsp.done) begin
          g_r <= cpgi_pkg::clamp_db(interp);
        end
      end
      cpgi_pkg::S_CONV: begin
        shf_r <= shf_w[14:0];
        a_r   <= '0;
      end
      cpgi_pkg::S_DB: begin
        if (16'(shf_r) >= cpgi_pkg::DB_STEP) begin
          shf_r <= 15'(16'(shf_r) - cpgi_pkg::DB_STEP);
          a_r   <= a_r + 4'd1;
        end
      end
      cpgi_pkg::S_XWAIT: begin
        x_r    <= prod_r[65:34];
        term_r <= cpgi_pkg::ONE_Q30[31:0];
        sum_r  <= cpgi_pkg::ONE_Q30;
        k_r    <= 5'd1;
      end
      cpgi_pkg::S_TWAIT: begin
        if (div_rsp.done) begin
          term_r <= div_quo[31:0];
          sum_r  <= sum_r + 34'(div_quo[31:0]);
          k_r    <= k_r + 5'd1;
        end
      end
      cpgi_pkg::S_FRND: begin
        lin_r <= (|fin_mul[51:32]) ? 32'hFFFF_FFFF : fin_mul[31:0];
      end
      cpgi_pkg::S_FWAIT: begin
        if (div_rsp.done) begin
          lin_r <= (|div_quo[47:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= st_r;
      out_hit_r    <= hit_r;
      out_gdb_r    <= g_r;
      out_glin_r   <= lin_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.exact_hit   = out_hit_r;
  assign out_chan.gain_db     = out_gdb_r;
  assign out_chan.gain_linear = out_glin_r;
endmodule

>>> rtl/cpgi_checker.sv
// cpgi_checker: port-level assertions on the result channel, bound to the top
// level; depends on cpgi_pkg and circular_pattern_gain_interpolator
module cpgi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic               out_exact_hit,
  input logic signed [14:0] out_gain_db,
  input logic [31:0]        out_gain_linear
);
  // a waiting result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no result straight after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // error results carry no gain
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cpgi_pkg::ST_OK |->
      !out_exact_hit && out_gain_db == '0 && out_gain_linear == '0)
    else $error("error result carries a gain");

  // status code in use
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == cpgi_pkg::ST_OK || out_status == cpgi_pkg::ST_EMPTY ||
                  out_status == cpgi_pkg::ST_BAD_INDEX)
    else $error("unknown status code");

  // gain inside the saturated range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain_db <= 15'sd12288)
    else $error("gain above saturation limit");
endmodule

bind circular_pattern_gain_interpolator cpgi_checker u_cpgi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_exact_hit   (out_chan.exact_hit),
  .out_gain_db     (out_chan.gain_db),
  .out_gain_linear (out_chan.gain_linear)
);
